// File: hdl/kmd_pkg.sv
// Shared types, constants and the counter update rule of the key matrix debouncer.
// No dependencies; every other file but kmd_ram refers to it by scoped names.

package kmd_pkg;

    // Store geometry and counter size
    localparam int MAX_ROWS     = 16;
    localparam int MAX_COLUMNS  = 16;
    localparam int COUNTER_BITS = 8;

    // Field and register widths
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int THR_W      = 7;
    localparam int GEOM_W     = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    // Derived sizes
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PROD_W      = COL_W + GEOM_W + 1;
    localparam int CEIL_W      = THR_W + 1;
    localparam int CMP_W       = (CEIL_W > COUNTER_BITS) ? CEIL_W : COUNTER_BITS;

    localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RST    = 7'd5;
    localparam logic [GEOM_W-1:0] ROW_COUNT_RST    = 5'd16;
    localparam logic [GEOM_W-1:0] COLUMN_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             pressed_level;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] event_row;
        logic [COL_W-1:0] event_column;
        logic             now_pressed;
    } out_item_t;

    // Counter write-back request from the update stage to the store
    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [COUNTER_BITS-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic [COUNTER_BITS-1:0] count;
        logic                    evt;
    } upd_t;

    // Saturating up/down count with snap at the threshold
    function automatic upd_t count_update(logic [COUNTER_BITS-1:0] cnt,
                                          logic [THR_W-1:0]        thr,
                                          logic                    pressed);
        logic [CMP_W-1:0] c;
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] dbl;
        logic [CMP_W-1:0] ceil_v;
        upd_t             r;
        c      = CMP_W'(cnt);
        t      = CMP_W'(thr);
        dbl    = CMP_W'({thr, 1'b0});
        ceil_v = (dbl > CMP_W'(COUNTER_MAX)) ? CMP_W'(COUNTER_MAX) : dbl;
        r.evt  = 1'b0;
        if (!pressed) begin
            if (c != '0) begin
                c = c - 1'b1;
                if (c == t) begin
                    c     = '0;
                    r.evt = 1'b1;
                end
            end
        end else if (c < ceil_v) begin
            c = c + 1'b1;
            if (c == t) begin
                c     = ceil_v;
                r.evt = 1'b1;
            end
        end
        r.count = COUNTER_BITS'(c);
        return r;
    endfunction

endpackage

// File: hdl/kmd_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.

module kmd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, then read old contents on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/kmd_key_store.sv
// Per-key counter store: RAM, per-entry valid bits and a last-write bypass.
// Depends on kmd_pkg and kmd_ram.

module kmd_key_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [kmd_pkg::ADDR_W-1:0]       rd_addr,
    input  logic [kmd_pkg::ADDR_W-1:0]       lookup_addr,
    input  kmd_pkg::wr_req_t                 wr,
    output logic [kmd_pkg::COUNTER_BITS-1:0] lookup_count
);

    logic [kmd_pkg::STORE_DEPTH-1:0]  valid_reg;
    logic                             fwd_valid_reg;
    logic [kmd_pkg::ADDR_W-1:0]       fwd_addr_reg;
    logic [kmd_pkg::COUNTER_BITS-1:0] fwd_data_reg;
    logic [kmd_pkg::COUNTER_BITS-1:0] ram_q;

    kmd_ram #(
        .WIDTH (kmd_pkg::COUNTER_BITS),
        .DEPTH (kmd_pkg::STORE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Mark written entries; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
            fwd_valid_reg      <= 1'b1;
        end
    end

    // Hold the most recent write for the read that collides with it
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == lookup_addr)) begin
            lookup_count = fwd_data_reg;
        end else if (valid_reg[lookup_addr]) begin
            lookup_count = ram_q;
        end else begin
            lookup_count = '0;
        end
    end

endmodule

// File: hdl/key_matrix_debouncer_unit.sv
// Top level of the key matrix debouncer: input decode, counter update stage, result register.
// Depends on kmd_pkg and kmd_key_store.

// Takes one key sample per clock when not stalled and keeps one saturating counter per key
// in a 256 x 8 RAM, addressed as column * row count + row. A sample is decoded and its
// counter read in the cycle it is accepted; the update stage then updates and writes the
// counter back and loads any press or release event into the result register once it
// can advance. Sustained rate is one sample per clock when no event is stalled, set by
// the single read-modify-write of the counter RAM; a write that collides with the
// following read of the same key is bypassed. The input stalls only in reset or while a
// pending event waits behind an untaken result. Per-entry valid bits make the store read
// as zero right after reset: no clearing pass is needed. Samples outside the configured
// rows or columns are dropped without a result. The user must write configuration
// registers only while the block is idle; the block itself does not enforce it.

module key_matrix_debouncer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  kmd_pkg::in_item_t                s_data,
    // event output
    output logic                             m_valid,
    input  logic                             m_ready,
    output kmd_pkg::out_item_t               m_data,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    logic [kmd_pkg::THR_W-1:0]        thr_reg;
    logic [kmd_pkg::GEOM_W-1:0]       row_count_reg;
    logic [kmd_pkg::GEOM_W-1:0]       column_count_reg;

    logic [kmd_pkg::GEOM_W-1:0]       rows_eff;
    logic [kmd_pkg::GEOM_W-1:0]       cols_eff;
    logic [kmd_pkg::PROD_W-1:0]       in_index;
    logic                             in_hit;
    logic                             s_fire;

    logic                             s1_valid_reg;
    logic                             s1_hit_reg;
    logic [kmd_pkg::ADDR_W-1:0]       s1_addr_reg;
    kmd_pkg::in_item_t                s1_item_reg;

    logic [kmd_pkg::ADDR_W-1:0]       rd_addr;
    logic [kmd_pkg::COUNTER_BITS-1:0] lookup_count;
    kmd_pkg::upd_t                    upd;
    kmd_pkg::wr_req_t                 wr;
    logic                             s1_event;
    logic                             s1_adv;

    logic                             m_valid_reg;
    kmd_pkg::out_item_t               m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg          <= kmd_pkg::THRESHOLD_RST;
            row_count_reg    <= kmd_pkg::ROW_COUNT_RST;
            column_count_reg <= kmd_pkg::COLUMN_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kmd_pkg::REG_THRESHOLD: begin
                    thr_reg <= kmd_pkg::THR_W'(cfg_wr_data);
                end
                kmd_pkg::REG_ROW_COUNT: begin
                    row_count_reg <= kmd_pkg::GEOM_W'(cfg_wr_data);
                end
                kmd_pkg::REG_COLUMN_COUNT: begin
                    column_count_reg <= kmd_pkg::GEOM_W'(cfg_wr_data);
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp geometry to the store and decode the sample address
    always_comb begin
        rows_eff = (int'(row_count_reg) > kmd_pkg::MAX_ROWS)
                   ? kmd_pkg::GEOM_W'(kmd_pkg::MAX_ROWS) : row_count_reg;
        cols_eff = (int'(column_count_reg) > kmd_pkg::MAX_COLUMNS)
                   ? kmd_pkg::GEOM_W'(kmd_pkg::MAX_COLUMNS) : column_count_reg;
        in_index = kmd_pkg::PROD_W'(s_data.column) * kmd_pkg::PROD_W'(rows_eff)
                 + kmd_pkg::PROD_W'(s_data.row);
        in_hit   = (kmd_pkg::GEOM_W'(s_data.row) < rows_eff)
                && (kmd_pkg::GEOM_W'(s_data.column) < cols_eff)
                && (int'(in_index) < kmd_pkg::STORE_DEPTH);
    end

    // Update stage: count, write back, raise the event
    always_comb begin
        upd      = kmd_pkg::count_update(lookup_count, thr_reg, s1_item_reg.pressed_level);
        s1_event = s1_hit_reg && upd.evt;
        s1_adv   = s1_valid_reg && (!s1_event || !m_valid_reg || m_ready);
        s_ready  = aresetn && (!s1_valid_reg || s1_adv);
        s_fire   = s_valid && s_ready;
        rd_addr  = s_fire ? kmd_pkg::ADDR_W'(in_index) : s1_addr_reg;
        wr.en    = s1_adv && s1_hit_reg;
        wr.addr  = s1_addr_reg;
        wr.data  = upd.count;
    end

    kmd_key_store u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_addr      (rd_addr),
        .lookup_addr  (s1_addr_reg),
        .wr           (wr),
        .lookup_count (lookup_count)
    );

    // Advance the sample into the update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_hit_reg  <= in_hit;
            s1_addr_reg <= kmd_pkg::ADDR_W'(in_index);
            s1_item_reg <= s_data;
        end
    end

    // Result register: load an event, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_event) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_event) begin
            m_data_reg.event_row    <= s1_item_reg.row;
            m_data_reg.event_column <= s1_item_reg.column;
            m_data_reg.now_pressed  <= s1_item_reg.pressed_level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/kmd_checker.sv
// Port-level checks of the key matrix debouncer and the bind that attaches them.
// Depends on kmd_pkg and key_matrix_debouncer_unit.

module kmd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input kmd_pkg::in_item_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input kmd_pkg::out_item_t             m_data
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result transaction holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A fresh result has an accepted sample behind it
    a_result_has_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a sample");

    // A fresh result names the key and level of that sample
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.event_row == $past(s_data.row, 2))
                        && (m_data.event_column == $past(s_data.column, 2))
                        && (m_data.now_pressed == $past(s_data.pressed_level, 2)))
        else $error("result does not match its sample");

endmodule

bind key_matrix_debouncer_unit kmd_checker u_kmd_checker (.*);
